// ===== rtl/repa_pkg.sv =====
package repa_pkg;

   // Config port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X       = 4'd0,
      CSR_CENTER_Y       = 4'd1,
      CSR_COS_THETA      = 4'd2,
      CSR_SIN_THETA      = 4'd3,
      CSR_INV_MAJOR_SQ   = 4'd4,
      CSR_INV_MINOR_SQ   = 4'd5,
      CSR_GREY_LEVEL     = 4'd6,
      CSR_INV_EDGE_WIDTH = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] cos_theta;
      logic signed [15:0] sin_theta;
      logic        [23:0] inv_major_sq;
      logic        [23:0] inv_minor_sq;
      logic signed [19:0] grey_level;
      logic        [23:0] inv_edge_width;
   } cfg_type;

   // Logistic table
   localparam int LOGISTIC_TABLE_DEPTH = 256;
   localparam int ROM_IDX_W = (LOGISTIC_TABLE_DEPTH > 1) ? $clog2(LOGISTIC_TABLE_DEPTH) : 1;
   localparam int ROM_W     = 17;
   localparam logic [ROM_W-1:0] ENTRY_ONE  = 17'h10000;
   localparam logic [ROM_W-1:0] ENTRY_ZERO = 17'h00000;

   // Table argument: offset t, 26 bits, times depth, top bits give the bin
   localparam int TOFF_W   = 26;
   localparam int KPROD_W  = TOFF_W + $clog2(LOGISTIC_TABLE_DEPTH + 1);

   // Fixed point constants
   localparam logic [36:0]        ONE_Q14_D = 37'd16384;
   localparam logic signed [37:0] ONE_Q14_S = 38'sd16384;
   localparam logic signed [37:0] DIFF_LO   = -38'sd33554432;
   localparam logic signed [37:0] DIFF_HI   = 38'sd33554432;
   localparam logic signed [51:0] T_LO      = -52'sd33554432;
   localparam logic signed [51:0] T_HI      = 52'sd33554431;
   localparam logic signed [51:0] T_BIAS    = 52'sd33554432;
   localparam logic signed [24:0] SAT_MAX   = 25'sd8388607;
   localparam logic signed [24:0] SAT_MIN   = -25'sd8388608;

   // Front pipeline length and queue
   localparam int FRONT_STAGES = 9;
   localparam int QUEUE_PTR_W  = 4;
   localparam int QUEUE_DEPTH  = 2 ** QUEUE_PTR_W;
   localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;

   // One classified pixel word on its way to the back end
   typedef struct packed {
      logic signed [23:0]    sample;
      logic                  in_ellipse;
      logic                  hard;
      logic [ROM_IDX_W-1:0]  idx;
   } item_type;

   typedef logic [ROM_W-1:0] rom_type [LOGISTIC_TABLE_DEPTH];

   // Shift-subtract quotient for the table build; both operands non-negative
   function automatic longint udiv(longint dividend, longint divisor);
      longint quo;
      longint rem;
      quo = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((dividend >>> b) & 64'sd1);
         if (rem >= divisor) begin
            rem = rem - divisor;
            quo = quo | (64'sd1 <<< b);
         end
      end
      return quo;
   endfunction

   // Entry k: round(65536 / (1 + exp(x_k))), x_k the bin centre on [-8, 8).
   // e^-|x| = (e^-(|x|/16))^16, series then four squarings, Q.30.
   function automatic rom_type build_rom();
      rom_type rom;
      longint  xq;
      longint  a;
      longint  y;
      longint  term;
      longint  sum;
      longint  den;
      longint  num;
      for (int k = 0; k < LOGISTIC_TABLE_DEPTH; k++) begin
         xq = ((longint'(2 * k + 1) <<< 35) / LOGISTIC_TABLE_DEPTH) - (64'sd1 <<< 35);
         a = (xq < 0) ? -xq : xq;
         y = a >>> 6;
         term = 64'sd1 <<< 30;
         sum  = 64'sd1 <<< 30;
         for (int n = 1; n <= 24; n++) begin
            term = udiv((term * y) >>> 30, longint'(n));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         for (int n = 0; n < 4; n++) begin
            sum = (sum * sum + (64'sd1 <<< 29)) >>> 30;
         end
         den = (64'sd1 <<< 30) + sum;
         num = (xq >= 0) ? (sum <<< 16) : (64'sd1 <<< 46);
         rom[k] = ROM_W'(udiv(num + den / 2, den));
      end
      return rom;
   endfunction

   localparam rom_type LOGISTIC_ROM = build_rom();

endpackage

// ===== rtl/repa_front.sv =====
module repa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic signed [15:0]   pixel_x,
   input  logic signed [15:0]   pixel_y,
   input  logic signed [23:0]   sample_in,
   input  repa_pkg::cfg_type    cfg,
   output logic                 push_valid,
   output repa_pkg::item_type   push_item
);

   logic [repa_pkg::FRONT_STAGES-1:0] valid_ff, valid_in;
   logic signed [23:0] sample_pipe_ff [repa_pkg::FRONT_STAGES];
   logic signed [23:0] sample_pipe_in [repa_pkg::FRONT_STAGES];

   logic signed [16:0] xo_ff, xo_in, yo_ff, yo_in;
   logic signed [32:0] pxc_ff, pxc_in, pys_ff, pys_in, pyc_ff, pyc_in, pxs_ff, pxs_in;
   logic signed [33:0] rx_sum, ry_sum;
   logic signed [19:0] xr_ff, xr_in, yr_ff, yr_in;
   logic signed [39:0] xsq, ysq;
   logic        [25:0] xs_ff, xs_in, ys_ff, ys_in;
   logic        [49:0] xprod, yprod;
   logic        [35:0] xterm_ff, xterm_in, yterm_ff, yterm_in;
   logic        [36:0] d_ff, d_in;
   logic signed [37:0] diff;
   logic signed [26:0] diffc_ff, diffc_in;
   logic signed [51:0] t_ff, t_in, t_biased;
   logic [repa_pkg::TOFF_W-1:0]  toff_ff, toff_in;
   logic [repa_pkg::KPROD_W-1:0] kprod;
   logic inside6_ff, inside6_in, inside7_ff, inside8_ff, inside9_ff;

   always_comb begin
      valid_in = {valid_ff[repa_pkg::FRONT_STAGES-2:0], in_accept};
      sample_pipe_in[0] = sample_in;
      for (int i = 1; i < repa_pkg::FRONT_STAGES; i++) begin
         sample_pipe_in[i] = sample_pipe_ff[i-1];
      end

      // offset
      xo_in = 17'(pixel_x) - 17'(cfg.center_x);
      yo_in = 17'(pixel_y) - 17'(cfg.center_y);

      // rotation products
      pxc_in = 33'(xo_ff) * 33'(cfg.cos_theta);
      pys_in = 33'(yo_ff) * 33'(cfg.sin_theta);
      pyc_in = 33'(yo_ff) * 33'(cfg.cos_theta);
      pxs_in = 33'(xo_ff) * 33'(cfg.sin_theta);

      // sums, flooring shift by 14
      rx_sum = 34'(pxc_ff) + 34'(pys_ff);
      ry_sum = 34'(pyc_ff) - 34'(pxs_ff);
      xr_in  = rx_sum[33:14];
      yr_in  = ry_sum[33:14];

      // squares
      xsq   = 40'(xr_ff) * 40'(xr_ff);
      ysq   = 40'(yr_ff) * 40'(yr_ff);
      xs_in = xsq[39:14];
      ys_in = ysq[39:14];

      // axis weighting
      xprod    = 50'(xs_ff) * 50'(cfg.inv_major_sq);
      yprod    = 50'(ys_ff) * 50'(cfg.inv_minor_sq);
      xterm_in = xprod[49:14];
      yterm_in = yprod[49:14];

      // normalised distance
      d_in       = 37'(xterm_ff) + 37'(yterm_ff);
      inside6_in = d_in < repa_pkg::ONE_Q14_D;

      // d - 1, clamped: beyond +-2^25 the table argument saturates anyway
      diff = $signed({1'b0, d_ff}) - repa_pkg::ONE_Q14_S;
      if (diff < repa_pkg::DIFF_LO) begin
         diffc_in = 27'(repa_pkg::DIFF_LO);
      end else if (diff > repa_pkg::DIFF_HI) begin
         diffc_in = 27'(repa_pkg::DIFF_HI);
      end else begin
         diffc_in = diff[26:0];
      end

      // scale by edge slope
      t_in = 52'(diffc_ff) * 52'($signed({1'b0, cfg.inv_edge_width}));

      // clamp and bias to [0, 2^26)
      t_biased = t_ff + repa_pkg::T_BIAS;
      if (t_ff < repa_pkg::T_LO) begin
         toff_in = '0;
      end else if (t_ff > repa_pkg::T_HI) begin
         toff_in = '1;
      end else begin
         toff_in = t_biased[repa_pkg::TOFF_W-1:0];
      end

      // bin index
      kprod = repa_pkg::KPROD_W'(toff_ff)
            * repa_pkg::KPROD_W'(repa_pkg::LOGISTIC_TABLE_DEPTH);

      push_valid           = valid_ff[repa_pkg::FRONT_STAGES-1];
      push_item.sample     = sample_pipe_ff[repa_pkg::FRONT_STAGES-1];
      push_item.in_ellipse = inside9_ff;
      push_item.hard       = cfg.inv_edge_width == 24'd0;
      push_item.idx        = kprod[repa_pkg::TOFF_W +: repa_pkg::ROM_IDX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_pipe_ff <= sample_pipe_in;
      xo_ff      <= xo_in;
      yo_ff      <= yo_in;
      pxc_ff     <= pxc_in;
      pys_ff     <= pys_in;
      pyc_ff     <= pyc_in;
      pxs_ff     <= pxs_in;
      xr_ff      <= xr_in;
      yr_ff      <= yr_in;
      xs_ff      <= xs_in;
      ys_ff      <= ys_in;
      xterm_ff   <= xterm_in;
      yterm_ff   <= yterm_in;
      d_ff       <= d_in;
      inside6_ff <= inside6_in;
      diffc_ff   <= diffc_in;
      inside7_ff <= inside6_ff;
      t_ff       <= t_in;
      inside8_ff <= inside7_ff;
      toff_ff    <= toff_in;
      inside9_ff <= inside8_ff;
   end

endmodule

// ===== rtl/repa_queue.sv =====
module repa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic                push_valid,
   input  repa_pkg::item_type  push_item,
   input  logic                pop,
   output logic                head_valid,
   output repa_pkg::item_type  head_item,
   output logic                credit_ok
);

   repa_pkg::item_type mem_ff [repa_pkg::QUEUE_DEPTH];
   logic [repa_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [repa_pkg::QUEUE_CNT_W-1:0] count_ff, count_in, pending_ff, pending_in;

   // pending covers words still in the front pipe plus words queued,
   // so a granted word always finds a free slot
   always_comb begin
      wr_ptr_in  = wr_ptr_ff + repa_pkg::QUEUE_PTR_W'(push_valid);
      rd_ptr_in  = rd_ptr_ff + repa_pkg::QUEUE_PTR_W'(pop);
      count_in   = count_ff + repa_pkg::QUEUE_CNT_W'(push_valid)
                 - repa_pkg::QUEUE_CNT_W'(pop);
      pending_in = pending_ff + repa_pkg::QUEUE_CNT_W'(in_accept)
                 - repa_pkg::QUEUE_CNT_W'(pop);
      head_valid = count_ff != '0;
      head_item  = mem_ff[rd_ptr_ff];
      credit_ok  = pending_ff < repa_pkg::QUEUE_CNT_W'(repa_pkg::QUEUE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/repa_back.sv =====
module repa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  repa_pkg::item_type  head_item,
   input  logic signed [19:0]  grey_level,
   input  logic                rsp_stall,
   output logic                pop,
   output logic                rsp_valid,
   output logic signed [23:0]  rsp_sample_out,
   output logic                rsp_inside_res
);

   logic adv;
   logic v1_ff, v1_in, v2_ff, v2_in, out_valid_ff, out_valid_in;
   logic [repa_pkg::ROM_W-1:0] entry_ff, entry_in;
   logic signed [23:0] s1_ff, s2_ff;
   logic i1_ff, i2_ff;
   logic signed [37:0] prod_ff, prod_in;
   logic signed [21:0] contrib;
   logic signed [24:0] res;
   logic signed [23:0] out_sample_ff, out_sample_in;
   logic out_inside_ff;

   always_comb begin
      adv = !out_valid_ff || !rsp_stall;
      pop = adv && head_valid;

      v1_in        = head_valid;
      v2_in        = v1_ff;
      out_valid_in = v2_ff;

      // hard edge uses unity or zero weight
      if (head_item.hard) begin
         entry_in = head_item.in_ellipse ? repa_pkg::ENTRY_ONE : repa_pkg::ENTRY_ZERO;
      end else begin
         entry_in = repa_pkg::LOGISTIC_ROM[head_item.idx];
      end

      prod_in = 38'(grey_level) * 38'($signed({1'b0, entry_ff}));

      contrib = prod_ff[37:16];
      res     = 25'(s2_ff) + 25'(contrib);
      if (res > repa_pkg::SAT_MAX) begin
         out_sample_in = 24'(repa_pkg::SAT_MAX);
      end else if (res < repa_pkg::SAT_MIN) begin
         out_sample_in = 24'(repa_pkg::SAT_MIN);
      end else begin
         out_sample_in = res[23:0];
      end

      rsp_valid      = out_valid_ff;
      rsp_sample_out = out_sample_ff;
      rsp_inside_res = out_inside_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff      <= entry_in;
         s1_ff         <= head_item.sample;
         i1_ff         <= head_item.in_ellipse;
         prod_ff       <= prod_in;
         s2_ff         <= s1_ff;
         i2_ff         <= i1_ff;
         out_sample_ff <= out_sample_in;
         out_inside_ff <= i2_ff;
      end
   end

endmodule

// ===== rtl/rotated_ellipse_pixel_accumulate_top.sv =====
// Path: an accepted pixel word passes 8 further front stages, one queue slot and 3 back
//   stages, then is offered as a result word.
// Throughput: one word per cycle; the 16-word credit covers every word between acceptance
//   and queue pop, so the input only stalls while results are held off.
// Reset: synchronous, active high; clears pipe valids, queue pointers and counts,
//   and loads the ellipse registers with their defaults. No clearing pass.
module rotated_ellipse_pixel_accumulate_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel words in
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [15:0]                    req_pixel_x,
   input  logic signed [15:0]                    req_pixel_y,
   input  logic signed [23:0]                    req_sample_in,
   // result words out
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [23:0]                    rsp_sample_out,
   output logic                                  rsp_inside_res,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [repa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [repa_pkg::CSR_DATA_W-1:0]       csr_data
);

   repa_pkg::cfg_type  cfg_ff, cfg_in;
   repa_pkg::item_type push_item, head_item;
   logic push_valid, head_valid, pop, credit_ok, in_accept;

   // Register file: always ready; indices past the list fall through.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (repa_pkg::csr_index_type'(csr_index))
            repa_pkg::CSR_CENTER_X:       cfg_in.center_x       = csr_data[15:0];
            repa_pkg::CSR_CENTER_Y:       cfg_in.center_y       = csr_data[15:0];
            repa_pkg::CSR_COS_THETA:      cfg_in.cos_theta      = csr_data[15:0];
            repa_pkg::CSR_SIN_THETA:      cfg_in.sin_theta      = csr_data[15:0];
            repa_pkg::CSR_INV_MAJOR_SQ:   cfg_in.inv_major_sq   = csr_data[23:0];
            repa_pkg::CSR_INV_MINOR_SQ:   cfg_in.inv_minor_sq   = csr_data[23:0];
            repa_pkg::CSR_GREY_LEVEL:     cfg_in.grey_level     = csr_data[19:0];
            repa_pkg::CSR_INV_EDGE_WIDTH: cfg_in.inv_edge_width = csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x       <= 16'sd0;
         cfg_ff.center_y       <= 16'sd0;
         cfg_ff.cos_theta      <= 16'sd16384;   // 1.0
         cfg_ff.sin_theta      <= 16'sd0;
         cfg_ff.inv_major_sq   <= 24'd16384;    // unit axes
         cfg_ff.inv_minor_sq   <= 24'd16384;
         cfg_ff.grey_level     <= 20'sd0;
         cfg_ff.inv_edge_width <= 24'd0;        // hard edge
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Credit gate: the front never stalls internally, so a word is only
   // taken when the queue is sure to have room for it.
   assign req_stall = !credit_ok;
   assign in_accept = req_valid && credit_ok;

   // Front: offset, rotate, distance, edge classification and table index
   repa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .sample_in  (req_sample_in),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Short queue decoupling front from result-side stalls
   repa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .credit_ok  (credit_ok)
   );

   // Back: logistic weight, grey scaling, saturating accumulate, output register
   repa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .grey_level     (cfg_ff.grey_level),
      .rsp_stall      (rsp_stall),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

// ===== tb/rotated_ellipse_pixel_accumulate_top_test.sv =====
`timescale 1ns / 1ps

module rotated_ellipse_pixel_accumulate_top_test;

   // Cycles allowed after the last result word before the run ends.
   localparam int     DRAIN_CYCLES     = 30;
   localparam longint UNIT_Q14         = 16384;
   // Clamp of the logistic argument, Q.22: [-8, 8)
   localparam longint ARG_LIMIT        = longint'(1) <<< 25;
   localparam int     CSR_FIRST_UNUSED = repa_pkg::CSR_INV_EDGE_WIDTH + 1;
   localparam int     CSR_INDEX_COUNT  = 2 ** repa_pkg::CSR_IDX_W;
   localparam int     LONG_HOLD_CYCLES = 400;

   // Clock and reset; reset held from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Pixel words in
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic signed [15:0]   req_pixel_x   = '0;
   logic signed [15:0]   req_pixel_y   = '0;
   logic signed [23:0]   req_sample_in = '0;

   // Result words out
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic signed [23:0]   rsp_sample_out;
   logic                 rsp_inside_res;

   // Register writes
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [repa_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [repa_pkg::CSR_DATA_W-1:0]      csr_data  = '0;

   rotated_ellipse_pixel_accumulate_top u_dut (.*);

   always #6 clock = ~clock;

   typedef struct {
      logic signed [23:0] sample;
      logic               in_ellipse;
   } pixel_result_type;

   // Our copy of the ellipse registers, updated only when a write is taken
   repa_pkg::cfg_type ellipse;
   // Logistic weights in Q0.16, one per bin
   longint            sigmoid_q16 [repa_pkg::LOGISTIC_TABLE_DEPTH];
   // Expected result words, oldest first
   pixel_result_type  predicted_samples [$];

   int          mismatches      = 0;
   // Gap odds: one in N pixel words (request side) or cycles (result side) starts a burst; zero means none
   int unsigned req_gap_odds    = 0;
   int unsigned rsp_gap_odds    = 0;
   bit          steady          = 1'b0;
   // Set by a test to ask the result side for a long hold-off
   int          rsp_hold_cycles = 0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Bin weight: round(65536 / (1 + exp(x))), x the bin centre on [-8, 8).
   // exp(-|x|) is formed as a series in |x|/16 and squared four times, Q.30.
   function automatic longint sigmoid_weight(int k);
      longint centre, frac, term, series, den, num;
      centre = ((longint'(2 * k + 1) <<< 35) / longint'(repa_pkg::LOGISTIC_TABLE_DEPTH))
               - (longint'(1) <<< 35);
      frac   = ((centre < 0) ? -centre : centre) >>> 6;
      term   = longint'(1) <<< 30;
      series = longint'(1) <<< 30;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * frac) >>> 30) / longint'(n);
         if (n % 2 == 1) begin
            series = series - term;
         end else begin
            series = series + term;
         end
      end
      for (int n = 0; n < 4; n++) begin
         series = (series * series + (longint'(1) <<< 29)) >>> 30;
      end
      den = (longint'(1) <<< 30) + series;
      num = (centre >= 0) ? (series <<< 16) : (longint'(1) <<< 46);
      return (num + den / 2) / den;
   endfunction

   function automatic pixel_result_type predict_pixel(logic signed [15:0] px,
                                                      logic signed [15:0] py,
                                                      logic signed [23:0] acc);
      longint xo, yo, xr, yr, xs, ys, norm_dist, grey, arg, bin, contrib, total;
      pixel_result_type r;
      xo   = longint'(px) - longint'($signed(ellipse.center_x));
      yo   = longint'(py) - longint'($signed(ellipse.center_y));
      // rotate, flooring shifts back to Q.14
      xr   = (xo * longint'($signed(ellipse.cos_theta))
              + yo * longint'($signed(ellipse.sin_theta))) >>> 14;
      yr   = (yo * longint'($signed(ellipse.cos_theta))
              - xo * longint'($signed(ellipse.sin_theta))) >>> 14;
      xs   = (xr * xr) >>> 14;
      ys   = (yr * yr) >>> 14;
      norm_dist = ((xs * longint'(ellipse.inv_major_sq)) >>> 14)
                  + ((ys * longint'(ellipse.inv_minor_sq)) >>> 14);
      r.in_ellipse = (norm_dist < UNIT_Q14);
      grey = longint'($signed(ellipse.grey_level));
      if (ellipse.inv_edge_width == '0) begin
         contrib = r.in_ellipse ? grey : 0;
      end else begin
         arg = (norm_dist - UNIT_Q14) * longint'(ellipse.inv_edge_width);
         if (arg < -ARG_LIMIT) arg = -ARG_LIMIT;
         if (arg > ARG_LIMIT - 1) arg = ARG_LIMIT - 1;
         bin     = ((arg + ARG_LIMIT) * repa_pkg::LOGISTIC_TABLE_DEPTH) >>> 26;
         contrib = (grey * sigmoid_q16[bin]) >>> 16;
      end
      total = longint'(acc) + contrib;
      if (total > 8388607) total = 8388607;
      if (total < -8388608) total = -8388608;
      r.sample = 24'(total);
      return r;
   endfunction

   // Register decode as the block does it: narrow fields take the low bits
   function automatic void apply_reg(logic [repa_pkg::CSR_IDX_W-1:0] idx,
                                     logic [repa_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         repa_pkg::CSR_CENTER_X:       ellipse.center_x       = data[15:0];
         repa_pkg::CSR_CENTER_Y:       ellipse.center_y       = data[15:0];
         repa_pkg::CSR_COS_THETA:      ellipse.cos_theta      = data[15:0];
         repa_pkg::CSR_SIN_THETA:      ellipse.sin_theta      = data[15:0];
         repa_pkg::CSR_INV_MAJOR_SQ:   ellipse.inv_major_sq   = data;
         repa_pkg::CSR_INV_MINOR_SQ:   ellipse.inv_minor_sq   = data;
         repa_pkg::CSR_GREY_LEVEL:     ellipse.grey_level     = data[19:0];
         repa_pkg::CSR_INV_EDGE_WIDTH: ellipse.inv_edge_width = data;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result side: stall driver and checker
   // ------------------------------------------------------------------

   // Random stall bursts, plus a long hold-off when a test asks for one
   initial begin : rsp_flow
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (!steady && rsp_gap_odds != 0 && $urandom_range(1, rsp_gap_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_samples.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word: sample_out %0d inside_res %0b",
                        rsp_sample_out, rsp_inside_res);
            mismatches++;
         end else begin
            want = predicted_samples.pop_front();
            if (rsp_sample_out !== want.sample || rsp_inside_res !== want.in_ellipse) begin
               if (mismatches < 10)
                  $display("mismatch: sample_out %0d expected %0d, inside_res %0b expected %0b",
                           rsp_sample_out, want.sample, rsp_inside_res, want.in_ellipse);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Pixel side and register writes
   // ------------------------------------------------------------------

   // Offer one pixel word, hold it until taken, then maybe idle for a burst
   task automatic send_pixel(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [23:0] acc);
      req_pixel_x   <= px;
      req_pixel_y   <= py;
      req_sample_in <= acc;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted_samples.push_back(predict_pixel(px, py, acc));
      if (!steady && req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected word has come back
   task automatic await_idle();
      req_valid <= 1'b0;
      while (predicted_samples.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes do not toggle it
   task automatic write_reg(logic [repa_pkg::CSR_IDX_W-1:0] idx,
                            logic [repa_pkg::CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Whole ellipse; unused upper data bits carry junk, which must be ignored
   task automatic program_ellipse(repa_pkg::cfg_type c);
      logic [23:0] junk;
      junk = 24'($urandom);
      await_idle();
      write_reg(repa_pkg::CSR_CENTER_X,       {junk[7:0], c.center_x});
      write_reg(repa_pkg::CSR_CENTER_Y,       {junk[15:8], c.center_y});
      write_reg(repa_pkg::CSR_COS_THETA,      {junk[23:16], c.cos_theta});
      write_reg(repa_pkg::CSR_SIN_THETA,      {junk[11:4], c.sin_theta});
      write_reg(repa_pkg::CSR_INV_MAJOR_SQ,   c.inv_major_sq);
      write_reg(repa_pkg::CSR_INV_MINOR_SQ,   c.inv_minor_sq);
      write_reg(repa_pkg::CSR_GREY_LEVEL,     {junk[19:16], c.grey_level});
      write_reg(repa_pkg::CSR_INV_EDGE_WIDTH, c.inv_edge_width);
      end_writes();
   endtask

   function automatic int pick_extreme(int lo, int hi, int rnd);
      case ($urandom_range(0, 2))
         0:       return lo;
         1:       return hi;
         default: return rnd;
      endcase
   endfunction

   // Plausible phantom ellipse, or with extreme flag set, fields at their limits or at random
   function automatic repa_pkg::cfg_type random_ellipse(bit extreme);
      repa_pkg::cfg_type c;
      real               ang;
      if (extreme) begin
         c.center_x       = 16'(pick_extreme(-32768, 32767, int'($urandom)));
         c.center_y       = 16'(pick_extreme(-32768, 32767, int'($urandom)));
         c.cos_theta      = 16'(pick_extreme(-16384, 16384, int'($urandom)));
         c.sin_theta      = 16'(pick_extreme(-16384, 16384, int'($urandom)));
         c.inv_major_sq   = 24'(pick_extreme(0, 16777215, int'($urandom)));
         c.inv_minor_sq   = 24'(pick_extreme(0, 16777215, int'($urandom)));
         c.grey_level     = 20'(pick_extreme(-524288, 524287, int'($urandom)));
         c.inv_edge_width = 24'(pick_extreme(1, 16777215, int'($urandom)));
         if ($urandom_range(0, 2) == 0) c.inv_edge_width = '0;
      end else begin
         ang              = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
         c.center_x       = 16'(int'($urandom_range(0, 16384)) - 8192);
         c.center_y       = 16'(int'($urandom_range(0, 16384)) - 8192);
         c.cos_theta      = 16'($rtoi($floor(16384.0 * $cos(ang) + 0.5)));
         c.sin_theta      = 16'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
         c.inv_major_sq   = 24'($urandom_range(16384, 16384 * 100));
         c.inv_minor_sq   = 24'($urandom_range(16384, 16384 * 100));
         c.grey_level     = 20'($urandom);
         c.inv_edge_width = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(256, 40000));
      end
      return c;
   endfunction

   // Mostly pixels on the unit square with modest sums; some words are pure noise
   task automatic send_random_pixel();
      logic signed [15:0] px, py;
      logic signed [23:0] acc;
      if ($urandom_range(0, 4) != 0) begin
         px = 16'(int'($urandom_range(0, 32768)) - 16384);
         py = 16'(int'($urandom_range(0, 32768)) - 16384);
      end else begin
         px = 16'($urandom);
         py = 16'($urandom);
      end
      case ($urandom_range(0, 7))
         0:       acc = 24'($urandom);
         1:       acc = 24'sd8388607 - 24'($urandom_range(0, 200000));
         2:       acc = -24'sd8388608 + 24'($urandom_range(0, 200000));
         default: acc = 24'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
      send_pixel(px, py, acc);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset registers: unit circle, grey zero, hard edge; the sum passes through
   task automatic test_reset_defaults();
      send_pixel(16'sd0, 16'sd0, 24'sd0);
      send_pixel(16'sd16384, 16'sd0, 24'sd8388607);     // d exactly one: outside
      send_pixel(16'sd16383, 16'sd0, -24'sd8388608);    // just inside
      send_pixel(-16'sd32768, -16'sd32768, 24'sd12345);
      send_pixel(16'sd32767, 16'sd32767, -24'sd1);
   endtask

   // Writes to indexes past the list must leave the registers alone
   task automatic test_unused_indexes();
      await_idle();
      for (int i = CSR_FIRST_UNUSED; i < CSR_INDEX_COUNT; i++) begin
         write_reg(repa_pkg::CSR_IDX_W'(i), 24'($urandom));
      end
      end_writes();
      send_pixel(16'sd100, -16'sd100, 24'sd777);
   endtask

   // Rotated ellipse, hard edge, saturation at both ends of the sum
   task automatic test_hard_edge();
      repa_pkg::cfg_type c;
      c.center_x       = 16'sd8192;
      c.center_y       = -16'sd8192;
      c.cos_theta      = 16'sd11585;                   // 45 degrees
      c.sin_theta      = 16'sd11585;
      c.inv_major_sq   = 24'd65536;                    // a = 0.5
      c.inv_minor_sq   = 24'd262144;                   // b = 0.25
      c.grey_level     = 20'sd524287;
      c.inv_edge_width = 24'd0;
      program_ellipse(c);
      send_pixel(16'sd8192, -16'sd8192, 24'sd8388607);  // centre, saturates high
      send_pixel(16'sd8192, -16'sd8192, 24'sd1000);
      send_pixel(16'sd12000, -16'sd4400, -24'sd5000);
      send_pixel(16'sd13000, -16'sd13000, 24'sd0);
      send_pixel(16'sd32767, -16'sd32768, 24'sd0);
      send_pixel(-16'sd32768, 16'sd32767, 24'sd42);
      c.grey_level = -20'sd524288;
      program_ellipse(c);
      send_pixel(16'sd8192, -16'sd8192, -24'sd8388608); // saturates low
      send_pixel(16'sd9000, -16'sd8000, 24'sd300000);
   endtask

   // Logistic edge: points across the rim, and past both ends of the table
   task automatic test_soft_edge();
      repa_pkg::cfg_type c;
      c.center_x       = 16'sd0;
      c.center_y       = 16'sd0;
      c.cos_theta      = 16'sd16384;
      c.sin_theta      = 16'sd0;
      c.inv_major_sq   = 24'd16384;
      c.inv_minor_sq   = 24'd16384;
      c.grey_level     = 20'sd65536;
      c.inv_edge_width = 24'd2560;                     // w = 0.1
      program_ellipse(c);
      send_pixel(16'sd0, 16'sd0, 24'sd0);              // clamped to first bin
      send_pixel(16'sd14000, 16'sd0, 24'sd0);
      send_pixel(16'sd16384, 16'sd0, 24'sd0);
      send_pixel(16'sd18000, 16'sd0, 24'sd0);
      send_pixel(16'sd23170, 16'sd23170, 24'sd0);
      send_pixel(16'sd32767, 16'sd32767, 24'sd0);      // clamped to last bin
      // out-of-range cosine used as given, steepest edge
      c.cos_theta      = -16'sd32768;
      c.sin_theta      = 16'sd16384;
      c.grey_level     = -20'sd300000;
      c.inv_edge_width = 24'hFFFFFF;
      program_ellipse(c);
      send_pixel(16'sd0, 16'sd0, 24'sd0);
      send_pixel(16'sd4000, 16'sd1000, 24'sd100);
      c.inv_edge_width = 24'd1;                        // widest edge
      program_ellipse(c);
      send_pixel(16'sd7000, -16'sd3000, 24'sd0);
      send_pixel(-16'sd32768, 16'sd0, 24'sd0);
   endtask

   // Result side holds off while words keep coming, so the block backs up;
   // then the sender waits for everything to drain
   task automatic test_back_pressure();
      program_ellipse(random_ellipse(1'b0));
      req_gap_odds    = 0;
      rsp_hold_cycles = LONG_HOLD_CYCLES;
      repeat (80) send_random_pixel();
      await_idle();
   endtask

   task automatic test_random_ellipses();
      for (int phase = 0; phase < 12; phase++) begin
         program_ellipse(random_ellipse(phase % 4 == 3));
         // in some phases one side runs without any idling
         req_gap_odds = (phase % 3 == 1) ? 0 : $urandom_range(2, 12);
         rsp_gap_odds = (phase % 3 == 2) ? 0 : $urandom_range(2, 12);
         repeat (110) send_random_pixel();
      end
   endtask

   // Last part: full rate on both sides
   task automatic test_steady_stream();
      program_ellipse(random_ellipse(1'b0));
      steady = 1'b1;
      repeat (300) send_random_pixel();
   endtask

   initial begin : run
      for (int k = 0; k < repa_pkg::LOGISTIC_TABLE_DEPTH; k++) begin
         sigmoid_q16[k] = sigmoid_weight(k);
      end
      ellipse.center_x       = '0;
      ellipse.center_y       = '0;
      ellipse.cos_theta      = 16'sd16384;
      ellipse.sin_theta      = '0;
      ellipse.inv_major_sq   = 24'd16384;
      ellipse.inv_minor_sq   = 24'd16384;
      ellipse.grey_level     = '0;
      ellipse.inv_edge_width = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_odds = 4;
      rsp_gap_odds = 4;
      test_reset_defaults();
      test_unused_indexes();
      test_hard_edge();
      test_soft_edge();
      test_back_pressure();
      test_random_ellipses();
      test_steady_stream();

      await_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_samples.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin : watchdog
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/repa_pkg.sv
rtl/repa_front.sv
rtl/repa_queue.sv
rtl/repa_back.sv
rtl/rotated_ellipse_pixel_accumulate_top.sv
tb/rotated_ellipse_pixel_accumulate_top_test.sv
